>>> sv/periodic_task_selector_defines.svh
// ----------------------------------------------------------------------------
// Periodic task selector assertion macros
// Shorthand for clocked implication checks, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_SELECTOR_DEFINES_SVH
`define PERIODIC_TASK_SELECTOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define PTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pts_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task selector package
// Shared widths, reset values, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  localparam int TICK_W       = 16;
  localparam int TC_W         = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int OUT_TASK_W   = 2;
  localparam int PERIOD_REGS  = 4;
  localparam int MAX_TASKS_DEF = 4;

  localparam logic [TC_W-1:0]   TASK_COUNT_RST   = 3'd4;
  localparam logic [TICK_W-1:0] OVERRUN_RST      = 16'd32768;
  localparam logic [TICK_W-1:0] PERIOD_RST       = 16'd1000;
  localparam logic [TICK_W-1:0] SLEEP_START      = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERRUN_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD0       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD1       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD2       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD3       = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_SCAN,
    ST_FIN
  } pts_state_t;

endpackage

`default_nettype wire

>>> sv/periodic_task_selector.sv
// ----------------------------------------------------------------------------
// Periodic task selector
// Fixed-priority selection of the next periodic task on each completion.
// ----------------------------------------------------------------------------
// Each request reports that the current task finished at timer value
// in_now_ticks. The block adds that task's period to its due time, then walks
// the tasks from task 0 upward through one shared 16-bit adder: the first
// task whose wrapped lateness is below overrun_limit wins at once, otherwise
// the task with the smallest wrapped sleep wins, and the current task stays
// if none beats 65535. The walk visits 1 to task_count tasks, clamped to
// MAX_TASKS, and none when task_count is zero; it reads one due time per
// cycle. The next request can be taken in the cycle after the result is
// loaded. in_stall is high from acceptance until the result is loaded. A
// result still stalled in the output register holds the sequencer in its
// final state until it drains. A result waits in the output register while
// the next request is taken.
`default_nettype none

module periodic_task_selector
  import pts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [TICK_W-1:0]     cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [TICK_W-1:0]     in_now_ticks,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [OUT_TASK_W-1:0]      out_next_task,
  output logic [TICK_W-1:0]          out_run_at,
  output logic                       out_ready_now
);

  localparam int TASK_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW0    = $clog2(MAX_TASKS + 1);
  localparam int CW     = (CW0 > TC_W) ? CW0 : TC_W;

  // Configuration registers
  logic [TC_W-1:0]   task_count_r;
  logic [TICK_W-1:0] overrun_limit_r;
  logic [TICK_W-1:0] period_r [PERIOD_REGS];

  // Task state
  logic [TICK_W-1:0] due_r [MAX_TASKS];
  logic [TASK_W-1:0] cur_r;

  // Sequencer and working registers
  pts_state_t        state_r, state_nxt;
  logic [TICK_W-1:0] now_r;
  logic [TASK_W-1:0] idx_r, idx_nxt;
  logic [TASK_W-1:0] sel_r, sel_nxt;
  logic [TICK_W-1:0] sleep_min_r, sleep_min_nxt;

  // Output register
  logic                  out_valid_r;
  logic [OUT_TASK_W-1:0] out_task_r;
  logic [TICK_W-1:0]     out_run_r;
  logic                  out_ready_r;

  // Datapath signals
  logic [TASK_W-1:0] rd_addr;
  logic [TICK_W-1:0] rd_data;
  logic [TICK_W-1:0] cur_period;
  logic [TICK_W-1:0] op_a, op_b, alu_sum;
  logic              op_cin;
  logic              is_upd;
  logic              below_limit;
  logic [TICK_W-1:0] sleep_val;
  logic              sleep_less;
  logic [CW-1:0]     count_eff;
  logic              count_zero;
  logic              idx_last;
  logic              accept;
  logic              out_free;
  logic              due_we;
  logic              out_load;
  logic [TASK_W+OUT_TASK_W-1:0] sel_ext;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Clamp the active task count to the table depth
  always_comb begin
    if (CW'(task_count_r) > CW'(MAX_TASKS)) begin
      count_eff = CW'(MAX_TASKS);
    end else begin
      count_eff = CW'(task_count_r);
    end
  end
  assign count_zero = (count_eff == '0);
  assign idx_last   = ((CW'(idx_r) + CW'(1)) == count_eff);

  // Select the single due-time read address
  always_comb begin
    case (state_r)
      ST_UPD:  rd_addr = cur_r;
      ST_SCAN: rd_addr = idx_r;
      ST_FIN:  rd_addr = sel_r;
      default: rd_addr = cur_r;
    endcase
  end
  assign rd_data = due_r[rd_addr];

  // Period of the current task; tasks without a register get zero
  always_comb begin
    cur_period = '0;
    for (int k = 0; k < PERIOD_REGS; k++) begin
      if (32'(cur_r) == 32'(k)) begin
        cur_period = period_r[k];
      end
    end
  end

  // Shared adder: due + period while updating, now - due otherwise
  assign is_upd  = (state_r == ST_UPD);
  assign op_a    = is_upd ? rd_data : now_r;
  assign op_b    = is_upd ? cur_period : ~rd_data;
  assign op_cin  = !is_upd;
  assign alu_sum = op_a + op_b + TICK_W'(op_cin);

  assign below_limit = (alu_sum < overrun_limit_r);
  assign sleep_val   = ~alu_sum + TICK_W'(1);
  assign sleep_less  = (sleep_val < sleep_min_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        state_nxt = count_zero ? ST_FIN : ST_SCAN;
      end
      ST_SCAN: begin
        if (below_limit || idx_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs and working register updates
  always_comb begin
    in_stall      = 1'b1;
    due_we        = 1'b0;
    out_load      = 1'b0;
    idx_nxt       = idx_r;
    sel_nxt       = sel_r;
    sleep_min_nxt = sleep_min_r;
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        idx_nxt       = '0;
        sel_nxt       = cur_r;
        sleep_min_nxt = SLEEP_START;
      end
      ST_UPD: begin
        due_we = 1'b1;
      end
      ST_SCAN: begin
        if (below_limit) begin
          sel_nxt = idx_r;
        end else begin
          if (sleep_less) begin
            sleep_min_nxt = sleep_val;
            sel_nxt       = idx_r;
          end
          idx_nxt = idx_r + TASK_W'(1);
        end
      end
      ST_FIN: begin
        out_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        cur_r       <= sel_r;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r    <= TASK_COUNT_RST;
      overrun_limit_r <= OVERRUN_RST;
      for (int k = 0; k < PERIOD_REGS; k++) begin
        period_r[k] <= PERIOD_RST;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TASK_COUNT:    task_count_r    <= cfg_wdata[TC_W-1:0];
        CFG_OVERRUN_LIMIT: overrun_limit_r <= cfg_wdata;
        CFG_PERIOD0:       period_r[0]     <= cfg_wdata;
        CFG_PERIOD1:       period_r[1]     <= cfg_wdata;
        CFG_PERIOD2:       period_r[2]     <= cfg_wdata;
        CFG_PERIOD3:       period_r[3]     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Due times: cleared at reset, one write per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_TASKS; k++) begin
        due_r[k] <= '0;
      end
    end else if (due_we) begin
      due_r[cur_r] <= alu_sum;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r <= in_now_ticks;
    end
    idx_r       <= idx_nxt;
    sel_r       <= sel_nxt;
    sleep_min_r <= sleep_min_nxt;
  end

  // Result register
  assign sel_ext = {{OUT_TASK_W{1'b0}}, sel_r};
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_task_r  <= sel_ext[OUT_TASK_W-1:0];
      out_run_r   <= rd_data;
      out_ready_r <= below_limit;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_next_task = out_task_r;
  assign out_run_at    = out_run_r;
  assign out_ready_now = out_ready_r;

endmodule

`default_nettype wire

>>> sv/pts_checker.sv
// ----------------------------------------------------------------------------
// Periodic task selector port checker
// Watches the request and result ports of the selector over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_task_selector_defines.svh"

module pts_checker
  import pts_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [OUT_TASK_W-1:0] out_next_task,
  input wire logic [TICK_W-1:0]     out_run_at,
  input wire logic                  out_ready_now
);

  // Hold a stalled result
  `PTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_next_task) && $stable(out_run_at) && $stable(out_ready_now), "stalled result changed")

  // Stall the input once a request is taken
  `PTS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "request taken while busy")

  // A new result only comes out of a busy sequencer
  `PTS_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall), "result without a request")

endmodule

bind periodic_task_selector pts_checker u_pts_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_next_task (out_next_task),
  .out_run_at    (out_run_at),
  .out_ready_now (out_ready_now)
);

`default_nettype wire
